[rtl/rph_pkg.sv]
// Shared types, constants and palette table for the radar palette histogram.
package rph_pkg;

  localparam int unsigned NUM_BINS   = 16;
  localparam int unsigned BIN_W      = 4;
  localparam int unsigned COUNT_W    = 17;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [BIN_W-1:0]   UNMATCHED_BIN = 4'd0;
  localparam logic [BIN_W-1:0]   LAST_LEVEL    = 4'd15;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 17'h1FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STOP  = 1'd1;

  localparam logic [PIX_W-1:0] ROW_START_RST = 8'd8;
  localparam logic [PIX_W-1:0] ROW_STOP_RST  = 8'd249;

  // Palette colors packed as {blue, green, red}; entry 0 is transparent black.
  localparam logic [3*PIX_W-1:0] PALETTE [NUM_BINS] = '{
    24'h000000, 24'hFFF5F5, 24'hFFB4B4, 24'hFF7878,
    24'hFF1414, 24'hC3D800, 24'h909600, 24'h666600,
    24'h00FFFF, 24'h00C8FF, 24'h0096FF, 24'h0064FF,
    24'h0000FF, 24'h0000C8, 24'h000078, 24'h000028
  };

  typedef enum logic [1:0] {
    RO_IDLE,
    RO_DRAIN,
    RO_UNM,
    RO_LEVELS
  } ro_state_t;

  typedef struct packed {
    logic             active;
    logic [BIN_W-1:0] addr;
    logic             clear;
  } ro_ctl_t;

endpackage

[rtl/radar_palette_histogram_top.sv]
// Top level of the radar palette histogram: window registers, update stage and units.
//
//  channel | ports                                          | handshake
//  --------+------------------------------------------------+-----------------------------
//  pixel   | in_blue in_green in_red in_row in_last_pixel   | start & !busy
//  result  | out_level out_count out_unmatched out_last     | out_valid, one cycle each
//  config  | cfg_we cfg_addr cfg_wdata                      | cfg_we, written at once
//
// One pixel transfer per cycle while busy is low; the count memory is read as the
// pixel is taken and written back in the next cycle, with forwarding for the same bin
// in adjacent pixels. A last pixel holds busy while its own update finishes and the
// unmatched bin is read, then while levels 1 to 15 are read from the single memory
// read port. Results are registered, and the final one overlaps the first free cycle.
// Synchronous reset clears the control state and marks every bin as zero.
// Results cannot be stalled.
module radar_palette_histogram_top
  import rph_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [PIX_W-1:0]     in_blue,
  input  logic [PIX_W-1:0]     in_green,
  input  logic [PIX_W-1:0]     in_red,
  input  logic [PIX_W-1:0]     in_row,
  input  logic                 in_last_pixel,
  output logic                 out_valid,
  output logic [BIN_W-1:0]     out_level,
  output logic [COUNT_W-1:0]   out_count,
  output logic [COUNT_W-1:0]   out_unmatched,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [PIX_W-1:0]     cfg_wdata
);

  logic [PIX_W-1:0]   row_start_r;
  logic [PIX_W-1:0]   row_stop_r;
  logic [BIN_W-1:0]   cls_bin;
  logic               cls_hit;
  logic               accept;
  logic               p_valid_r;
  logic               p_hit_r;
  logic [BIN_W-1:0]   p_bin_r;
  logic [COUNT_W-1:0] rd_data;
  logic               wr_en;
  logic [COUNT_W-1:0] wr_data;
  logic [BIN_W-1:0]   rd_addr;
  ro_ctl_t            ro_ctl;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_start_r <= ROW_START_RST;
      row_stop_r  <= ROW_STOP_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ROW_START: row_start_r <= cfg_wdata;
        CFG_ROW_STOP:  row_stop_r  <= cfg_wdata;
        default:       row_start_r <= row_start_r;
      endcase
    end
  end

  rph_classify u_classify (
    .blue      (in_blue),
    .green     (in_green),
    .red       (in_red),
    .row       (in_row),
    .row_start (row_start_r),
    .row_stop  (row_stop_r),
    .bin       (cls_bin),
    .hit       (cls_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    p_hit_r <= cls_hit;
    p_bin_r <= cls_bin;
  end

  // Saturating increment of the bin read for the previous pixel.
  assign wr_en   = p_valid_r && p_hit_r && (rd_data != COUNT_MAX);
  assign wr_data = rd_data + 17'd1;
  assign rd_addr = ro_ctl.active ? ro_ctl.addr : cls_bin;

  rph_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (p_bin_r),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .clear   (ro_ctl.clear),
    .rd_data (rd_data)
  );

  rph_readout u_readout (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (accept && in_last_pixel),
    .rd_data       (rd_data),
    .ctl           (ro_ctl),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_level     (out_level),
    .out_count     (out_count),
    .out_unmatched (out_unmatched),
    .out_last      (out_last)
  );

  a_last_starts_readout: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_pixel |=> busy)
    else $error("last pixel did not start a readout");

  a_levels_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && (out_level == $past(out_level) + 4'd1))
    else $error("readout results not consecutive");

  // The final result shares its cycle with the first cycle that can take a pixel.
  a_readout_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy ##1 !out_valid)
    else $error("readout did not end after the final level");

  a_no_update_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> p_valid_r && !ro_ctl.clear)
    else $error("count write outside a pixel update");

endmodule

[rtl/rph_classify.sv]
// Palette matcher and row window test for one pixel.
module rph_classify
  import rph_pkg::*;
(
  input  logic [PIX_W-1:0] blue,
  input  logic [PIX_W-1:0] green,
  input  logic [PIX_W-1:0] red,
  input  logic [PIX_W-1:0] row,
  input  logic [PIX_W-1:0] row_start,
  input  logic [PIX_W-1:0] row_stop,
  output logic [BIN_W-1:0] bin,
  output logic             hit
);

  logic             matched;
  logic [BIN_W-1:0] lvl;
  logic             in_win;

  always_comb begin
    matched = 1'b0;
    lvl     = UNMATCHED_BIN;
    // Walk downward so the lowest matching level wins.
    for (int i = NUM_BINS - 1; i >= 0; i--) begin
      if (PALETTE[i] == {blue, green, red}) begin
        matched = 1'b1;
        lvl     = BIN_W'(i);
      end
    end
  end

  assign in_win = (row >= row_start) && (row <= row_stop);
  assign bin    = matched ? lvl : UNMATCHED_BIN;
  // Black is transparent and never tallied.
  assign hit    = in_win && (!matched || (lvl != UNMATCHED_BIN));

endmodule

[rtl/rph_store.sv]
// Count memory with per-entry valid bits and write-to-read forwarding.
module rph_store
  import rph_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [BIN_W-1:0]   wr_addr,
  input  logic [COUNT_W-1:0] wr_data,
  input  logic [BIN_W-1:0]   rd_addr,
  input  logic               clear,
  output logic [COUNT_W-1:0] rd_data
);

  logic [COUNT_W-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0] valid_r;
  logic [COUNT_W-1:0] mem_q_r;
  logic [COUNT_W-1:0] fwd_data_r;
  logic               fwd_r;
  logic               rd_vld_r;
  logic               same;

  assign same = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q_r    <= mem[rd_addr];
    fwd_data_r <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      fwd_r    <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      // A read in the same cycle as a write to that entry sees the new value.
      fwd_r    <= same;
      rd_vld_r <= !clear && (valid_r[rd_addr] || same);
      if (clear) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : (rd_vld_r ? mem_q_r : '0);

endmodule

[rtl/rph_readout.sv]
// Readout sequencer: drains the last update, then reports all levels.
module rph_readout
  import rph_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [COUNT_W-1:0] rd_data,
  output ro_ctl_t            ctl,
  output logic               busy,
  output logic               out_valid,
  output logic [BIN_W-1:0]   out_level,
  output logic [COUNT_W-1:0] out_count,
  output logic [COUNT_W-1:0] out_unmatched,
  output logic               out_last
);

  ro_state_t          state_r, state_nxt;
  logic [BIN_W-1:0]   ptr_r, ptr_nxt;
  logic [COUNT_W-1:0] unm_r;
  logic               out_valid_r;
  logic [BIN_W-1:0]   out_level_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [COUNT_W-1:0] out_unm_r;
  logic               out_last_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      RO_IDLE:   if (go) state_nxt = RO_DRAIN;
      RO_DRAIN:  state_nxt = RO_UNM;
      RO_UNM:    state_nxt = RO_LEVELS;
      RO_LEVELS: if (ptr_r == LAST_LEVEL) state_nxt = RO_IDLE;
      default:   state_nxt = RO_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    ctl.active = 1'b1;
    ctl.clear  = 1'b0;
    ctl.addr   = ptr_r + 4'd1;
    ptr_nxt    = ptr_r;
    case (state_r)
      RO_IDLE: begin
        busy       = 1'b0;
        ctl.active = 1'b0;
      end
      RO_DRAIN: begin
        // The unmatched read overlaps the final pixel's write; the store forwards it.
        ctl.addr = UNMATCHED_BIN;
      end
      RO_UNM: begin
        ctl.addr = 4'd1;
        ptr_nxt  = 4'd1;
      end
      RO_LEVELS: begin
        ptr_nxt   = ptr_r + 4'd1;
        ctl.clear = (ptr_r == LAST_LEVEL);
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= RO_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == RO_LEVELS);
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    out_level_r <= ptr_r;
    out_count_r <= rd_data;
    out_unm_r   <= unm_r;
    out_last_r  <= (ptr_r == LAST_LEVEL);
    if (state_r == RO_UNM) begin
      unm_r <= rd_data;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_level     = out_level_r;
  assign out_count     = out_count_r;
  assign out_unmatched = out_unm_r;
  assign out_last      = out_last_r;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for radar_palette_histogram_top: pixel stream in, per-level counts out.
module tb_top;
  import rph_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] row;
    logic             last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [BIN_W-1:0]   level;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] unmatched;
    logic               last;
  } bin_report_t;

  // Palette colors as {blue, green, red}, index = intensity level, level 0 is transparent.
  localparam logic [3*PIX_W-1:0] LEVEL_COLOR [16] = '{
    24'h000000, 24'hFFF5F5, 24'hFFB4B4, 24'hFF7878,
    24'hFF1414, 24'hC3D800, 24'h909600, 24'h666600,
    24'h00FFFF, 24'h00C8FF, 24'h0096FF, 24'h0064FF,
    24'h0000FF, 24'h0000C8, 24'h000078, 24'h000028
  };

  class palette_tally;
    logic [COUNT_W-1:0] tally [NUM_BINS];
    logic [PIX_W-1:0]   row_lo;
    logic [PIX_W-1:0]   row_hi;
    bin_report_t        pending_reports [$];
    int unsigned        errors;
    int unsigned        pixels;
    int unsigned        images;
    int unsigned        reports;

    function new();
      foreach (tally[i]) tally[i] = '0;
      row_lo  = ROW_START_RST;
      row_hi  = ROW_STOP_RST;
      errors  = 0;
      pixels  = 0;
      images  = 0;
      reports = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] val);
      case (idx)
        CFG_ROW_START: row_lo = val;
        CFG_ROW_STOP:  row_hi = val;
        default: ;
      endcase
    endfunction

    // Returns the palette level, or NUM_BINS when the color is not in the palette.
    function int match_level(pixel_t px);
      for (int i = 0; i < NUM_BINS; i++) begin
        if ({px.blue, px.green, px.red} == LEVEL_COLOR[i]) return i;
      end
      return NUM_BINS;
    endfunction

    function void take_pixel(pixel_t px);
      int lv;
      int bin;
      bin_report_t rep;
      pixels++;
      lv = match_level(px);
      if (px.row >= row_lo && px.row <= row_hi && lv != 0) begin
        bin = (lv == NUM_BINS) ? UNMATCHED_BIN : lv;
        if (tally[bin] != COUNT_MAX) tally[bin] = tally[bin] + 1'b1;
      end
      if (px.last_pixel) begin
        images++;
        for (int i = 1; i < NUM_BINS; i++) begin
          rep.level     = BIN_W'(i);
          rep.count     = tally[i];
          rep.unmatched = tally[UNMATCHED_BIN];
          rep.last      = (i == LAST_LEVEL);
          pending_reports.push_back(rep);
        end
        foreach (tally[i]) tally[i] = '0;
      end
    endfunction

    function void check_field(string name, logic [COUNT_W-1:0] exp_val,
                              logic [COUNT_W-1:0] got_val);
      if (got_val !== exp_val) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_val, got_val);
        errors++;
      end
    endfunction

    function void check_bin_report(bin_report_t got);
      bin_report_t exp_rep;
      reports++;
      if (pending_reports.size() == 0) begin
        $error("unexpected result transfer: level %0d count %0d", got.level, got.count);
        errors++;
        return;
      end
      exp_rep = pending_reports.pop_front();
      check_field("out_level", COUNT_W'(exp_rep.level), COUNT_W'(got.level));
      check_field("out_count", exp_rep.count, got.count);
      check_field("out_unmatched", exp_rep.unmatched, got.unmatched);
      check_field("out_last", COUNT_W'(exp_rep.last), COUNT_W'(got.last));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [PIX_W-1:0]     in_blue = '0;
  logic [PIX_W-1:0]     in_green = '0;
  logic [PIX_W-1:0]     in_red = '0;
  logic [PIX_W-1:0]     in_row = '0;
  logic                 in_last_pixel = 1'b0;
  logic                 out_valid;
  logic [BIN_W-1:0]     out_level;
  logic [COUNT_W-1:0]   out_count;
  logic [COUNT_W-1:0]   out_unmatched;
  logic                 out_last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = CFG_ROW_START;
  logic [PIX_W-1:0]     cfg_wdata = '0;

  palette_tally     sb;
  logic [PIX_W-1:0] win_lo = ROW_START_RST;
  logic [PIX_W-1:0] win_hi = ROW_STOP_RST;
  int unsigned      windows = 0;

  radar_palette_histogram_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_blue       (in_blue),
    .in_green      (in_green),
    .in_red        (in_red),
    .in_row        (in_row),
    .in_last_pixel (in_last_pixel),
    .out_valid     (out_valid),
    .out_level     (out_level),
    .out_count     (out_count),
    .out_unmatched (out_unmatched),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_bin_report('{out_level, out_count, out_unmatched, out_last});
    end
  end

  function automatic pixel_t pix(logic [3*PIX_W-1:0] bgr, logic [PIX_W-1:0] row,
                                 logic lastp);
    pixel_t px;
    {px.blue, px.green, px.red} = bgr;
    px.row        = row;
    px.last_pixel = lastp;
    return px;
  endfunction

  // Rows cluster on the window edges so both sides of each bound are hit often.
  function automatic pixel_t rand_pixel(logic [PIX_W-1:0] lo, logic [PIX_W-1:0] hi);
    logic [3*PIX_W-1:0] bgr;
    logic [PIX_W-1:0]   row;
    int                 pick;
    pick = $urandom_range(0, 19);
    if (pick < 10) begin
      bgr = LEVEL_COLOR[$urandom_range(0, 15)];
    end else if (pick < 13) begin
      bgr = LEVEL_COLOR[$urandom_range(1, 15)] ^ (24'd1 << $urandom_range(0, 23));
    end else begin
      bgr = 24'($urandom);
    end
    case ($urandom_range(0, 5))
      0: row = lo - 8'd1;
      1: row = lo;
      2: row = hi;
      3: row = hi + 8'd1;
      default: row = PIX_W'($urandom);
    endcase
    return pix(bgr, row, 1'b0);
  endfunction

  task automatic push_pixel(input pixel_t px);
    in_blue       <= px.blue;
    in_green      <= px.green;
    in_red        <= px.red;
    in_row        <= px.row;
    in_last_pixel <= px.last_pixel;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
    sb.take_pixel(px);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Waits for every pending result, then lets the update pipeline settle.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_window(input logic [PIX_W-1:0] lo, input logic [PIX_W-1:0] hi);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_ROW_START;
    cfg_wdata <= lo;
    @(posedge clk);
    sb.write_reg(CFG_ROW_START, lo);
    cfg_addr  <= CFG_ROW_STOP;
    cfg_wdata <= hi;
    @(posedge clk);
    sb.write_reg(CFG_ROW_STOP, hi);
    cfg_we <= 1'b0;
    win_lo = lo;
    win_hi = hi;
    windows++;
  endtask

  initial begin
    #15_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned        sent;
    int unsigned        img;
    int                 len;
    int                 waited;
    bit                 idle_on;
    pixel_t             px;
    logic [PIX_W-1:0]   lo;

    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed image under the reset window: every palette level, off-palette colors,
    // a near miss and rows on both sides of each window bound.
    for (int i = 0; i < 16; i++) push_pixel(pix(LEVEL_COLOR[i], 8'd100, 1'b0));
    push_pixel(pix(24'hFFFFFF, 8'd8, 1'b0));
    push_pixel(pix(24'hFFF5F4, 8'd249, 1'b0));
    push_pixel(pix(LEVEL_COLOR[12], 8'd7, 1'b0));
    push_pixel(pix(LEVEL_COLOR[12], 8'd250, 1'b0));
    push_pixel(pix(24'h000001, 8'd255, 1'b0));
    push_pixel(pix(24'h000001, 8'd0, 1'b0));
    push_pixel(pix(LEVEL_COLOR[15], 8'd128, 1'b1));
    // A readout right after another must report an empty store.
    push_pixel(pix(LEVEL_COLOR[0], 8'd0, 1'b1));

    // Random images; some end without a last mark so counts carry across a window change.
    sent = 0;
    img  = 0;
    while (sent < 300) begin
      case (img)
        0: set_window(8'd0, 8'd255);
        1: set_window(8'd200, 8'd100);
        2: set_window(8'd255, 8'd255);
        3: set_window(8'd0, 8'd0);
        default: begin
          if ($urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 3) == 0) begin
              set_window(PIX_W'($urandom), PIX_W'($urandom));
            end else begin
              lo = PIX_W'($urandom_range(0, 128));
              set_window(lo, lo + 8'($urandom_range(0, 127)));
            end
          end
        end
      endcase
      idle_on = (sent < 240) && ($urandom_range(0, 2) != 0);
      len = $urandom_range(1, 30);
      for (int k = 0; k < len; k++) begin
        px = rand_pixel(win_lo, win_hi);
        px.last_pixel = (k == len - 1) && ($urandom_range(0, 4) != 0);
        push_pixel(px);
        sent++;
        if (idle_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 18));
      end
      img++;
    end
    push_pixel(pix(LEVEL_COLOR[$urandom_range(1, 15)], win_lo, 1'b1));
    start <= 1'b0;

    waited = 0;
    while (sb.pending_reports.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending_reports.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_reports.size());
      sb.errors++;
    end
    repeat (20) @(posedge clk);

    $display("Run covered %0d pixel transfers and %0d readouts (%0d result transfers),",
             sb.pixels, sb.images, sb.reports);
    $display("over %0d row windows including empty and full ones.", windows + 1);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[radar_palette_histogram_top.f]
rtl/rph_pkg.sv
rtl/rph_classify.sv
rtl/rph_store.sv
rtl/rph_readout.sv
rtl/radar_palette_histogram_top.sv
test/tb_top.sv
